// ----- hdl/lcb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lcb_pkg;

   // Store addresses never reach the product limit, so six bits always suffice.
   localparam int ADDR_W        = 6;
   localparam int PRODUCT_LIMIT = 59;
   localparam int COLOR_W       = 24;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 7;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FANS_IN_USE  = 1'b0,
      CSR_LEDS_PER_FAN = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_SET_RED     = 3'd0,
      CMD_SET_GREEN   = 3'd1,
      CMD_SET_BLUE    = 3'd2,
      CMD_SET_RGBA    = 3'd3,
      CMD_FILL_FAN    = 3'd4,
      CMD_FILL_COLUMN = 3'd5,
      CMD_READ        = 3'd6,
      CMD_UNUSED      = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_FAN = 2'd1,
      ST_LED = 2'd2,
      ST_CFG = 2'd3
   } status_type;

   // What the back end has to do with a classified command.
   typedef enum logic [1:0] {
      KIND_RESP = 2'd0,
      KIND_READ = 2'd1,
      KIND_SET  = 2'd2,
      KIND_FILL = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      status_type          status;
      cmd_type             cmd;
      logic [7:0]          value;
      logic [ADDR_W-1:0]   addr;
      logic [ADDR_W-1:0]   step;
      logic [ADDR_W-1:0]   count;
      logic [15:0]         prod_red;
      logic [15:0]         prod_green;
      logic [15:0]         prod_blue;
   } entry_type;

   // floor(p / 255) for any p up to 65025 (255 * 255), the largest color-times-alpha product.
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] s;
      s = {1'b0, p} + {9'b0, p[15:8]} + 17'd1;
      return s[15:8];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/lcb_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- hdl/lcb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcb_front #(
   parameter int MAX_LEDS = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [2:0]                         req_command,
   input  wire logic [5:0]                         req_fan,
   input  wire logic [5:0]                         req_led,
   input  wire logic [7:0]                         req_channel_value,
   input  wire logic [31:0]                        req_rgba,
   input  wire logic [lcb_pkg::CSR_DATA_W-1:0]     fans_in_use,
   input  wire logic [lcb_pkg::CSR_DATA_W-1:0]     leds_per_fan,
   input  wire logic                               q_full,
   output logic                                    push,
   output lcb_pkg::entry_type                      push_entry
);
   import lcb_pkg::*;

   localparam int LIMIT = (MAX_LEDS < PRODUCT_LIMIT) ? MAX_LEDS : PRODUCT_LIMIT;

   logic        front_valid_ff, front_valid_in;
   entry_type   entry_ff, entry_in;
   logic        accept;
   cmd_type     cmd;
   logic [13:0] cfg_prod;
   logic [12:0] base;
   logic [13:0] addr_sum;
   logic        cfg_bad, fan_ok, led_ok;

   assign cmd      = cmd_type'(req_command);
   assign cfg_prod = 14'(fans_in_use) * 14'(leds_per_fan);
   assign cfg_bad  = cfg_prod > 14'(LIMIT);
   assign base     = 13'(req_fan) * 13'(leds_per_fan);
   assign addr_sum = {1'b0, base} + 14'(req_led);
   assign fan_ok   = {1'b0, req_fan} < fans_in_use;
   assign led_ok   = {1'b0, req_led} < leds_per_fan;

   always_comb begin
      entry_in            = '0;
      entry_in.kind       = KIND_RESP;
      entry_in.status     = ST_OK;
      entry_in.cmd        = cmd;
      entry_in.value      = req_channel_value;
      entry_in.addr       = addr_sum[ADDR_W-1:0];
      entry_in.step       = '0;
      entry_in.count      = ADDR_W'(1);
      entry_in.prod_red   = 16'(req_rgba[31:24]) * 16'(req_rgba[7:0]);
      entry_in.prod_green = 16'(req_rgba[23:16]) * 16'(req_rgba[7:0]);
      entry_in.prod_blue  = 16'(req_rgba[15:8]) * 16'(req_rgba[7:0]);
      if (cmd == CMD_UNUSED) begin
         entry_in.status = ST_OK;
      end else if (cfg_bad) begin
         entry_in.status = ST_CFG;
      end else begin
         unique case (cmd)
            CMD_FILL_FAN: begin
               if (!fan_ok) begin
                  entry_in.status = ST_FAN;
               end else begin
                  entry_in.kind  = KIND_FILL;
                  entry_in.addr  = base[ADDR_W-1:0];
                  entry_in.step  = ADDR_W'(1);
                  entry_in.count = leds_per_fan[ADDR_W-1:0];
               end
            end
            CMD_FILL_COLUMN: begin
               if (!led_ok) begin
                  entry_in.status = ST_LED;
               end else begin
                  entry_in.kind  = KIND_FILL;
                  entry_in.addr  = req_led;
                  entry_in.step  = leds_per_fan[ADDR_W-1:0];
                  entry_in.count = fans_in_use[ADDR_W-1:0];
               end
            end
            default: begin
               if (!fan_ok) begin
                  entry_in.status = ST_FAN;
               end else if (!led_ok) begin
                  entry_in.status = ST_LED;
               end else begin
                  unique case (cmd) inside
                     CMD_SET_RED, CMD_SET_GREEN, CMD_SET_BLUE: entry_in.kind = KIND_SET;
                     CMD_SET_RGBA:                             entry_in.kind = KIND_FILL;
                     default:                                  entry_in.kind = KIND_READ;
                  endcase
               end
            end
         endcase
      end
   end

   assign busy   = front_valid_ff && q_full;
   assign accept = start && !busy;
   assign push   = front_valid_ff && !q_full;

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign push_entry = entry_ff;

endmodule

`default_nettype wire

// ----- hdl/lcb_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcb_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire lcb_pkg::entry_type push_entry,
   input  wire logic               pop,
   output logic                    full,
   output logic                    not_empty,
   output lcb_pkg::entry_type      head
);
   import lcb_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full      = count_ff == CW'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/lcb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lcb_back #(
   parameter int MAX_LEDS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire lcb_pkg::entry_type q_head,
   output logic                    q_pop,
   output logic                    rsp_strobe,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue,
   output logic [1:0]              rsp_status
);
   import lcb_pkg::*;

   localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_MERGE = 3'b010,
      S_WALK  = 3'b100
   } back_state_type;

   back_state_type     state_ff, state_in;
   entry_type          work_ff, work_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [ADDR_W-1:0]  fill_position_ff, fill_position_in;
   logic [MAX_LEDS-1:0] valid_ff, valid_in;
   logic               strobe_ff, strobe_in;
   logic [7:0]         red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   status_type         status_ff, status_in;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr, ram_raddr;
   logic [COLOR_W-1:0] ram_wdata, ram_rdata;
   logic [COLOR_W-1:0] cur, merged;

   lcb_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (MAX_LEDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign ram_waddr = AW'(work_ff.addr);
   assign ram_raddr = (state_ff == S_IDLE) ? AW'(q_head.addr) : AW'(work_ff.addr);

   // An entry never written since reset reads as black.
   assign cur = valid_ff[ram_waddr] ? ram_rdata : '0;

   always_comb begin
      case (work_ff.cmd)
         CMD_SET_RED:   merged = {work_ff.value, cur[15:0]};
         CMD_SET_GREEN: merged = {cur[23:16], work_ff.value, cur[7:0]};
         default:       merged = {cur[23:8], work_ff.value};
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      work_in          = work_ff;
      color_in         = color_ff;
      fill_position_in = fill_position_ff;
      valid_in         = valid_ff;
      strobe_in        = 1'b0;
      red_in           = '0;
      green_in         = '0;
      blue_in          = '0;
      status_in        = ST_OK;
      q_pop            = 1'b0;
      ram_we           = 1'b0;
      ram_wdata        = color_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop            = 1'b1;
               work_in          = q_head;
               color_in         = {div255(q_head.prod_red), div255(q_head.prod_green),
                                   div255(q_head.prod_blue)};
               fill_position_in = '0;
               unique case (q_head.kind)
                  KIND_RESP: begin
                     strobe_in = 1'b1;
                     status_in = q_head.status;
                  end
                  KIND_READ, KIND_SET: begin
                     state_in = S_MERGE;
                  end
                  KIND_FILL: begin
                     if (q_head.count == '0) begin
                        strobe_in = 1'b1;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WALK: begin
            ram_we              = 1'b1;
            valid_in[ram_waddr] = 1'b1;
            work_in.addr        = work_ff.addr + work_ff.step;
            fill_position_in    = fill_position_ff + ADDR_W'(1);
            if (fill_position_ff == work_ff.count - ADDR_W'(1)) begin
               fill_position_in = '0;
               strobe_in        = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_MERGE: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            if (work_ff.kind == KIND_READ) begin
               {red_in, green_in, blue_in} = cur;
            end else begin
               ram_we              = 1'b1;
               ram_wdata           = merged;
               valid_in[ram_waddr] = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         fill_position_ff <= '0;
         valid_ff         <= '0;
         strobe_ff        <= 1'b0;
      end else begin
         state_ff         <= state_in;
         fill_position_ff <= fill_position_in;
         valid_ff         <= valid_in;
         strobe_ff        <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      color_ff  <= color_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      status_ff <= status_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_red    = red_ff;
   assign rsp_green  = green_ff;
   assign rsp_blue   = blue_ff;
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

// ----- hdl/led_color_buffer.sv -----
// The front end registers each command, the two-beat queue holds it and the back end
// takes one command at a time: a refused or unused command is answered as it is popped,
// a channel set or read passes through the merge state, and an RGBA write or a fill
// walks the store one LED after another (up to 59 LEDs). busy rises only when the front
// register and the queue are both occupied. Synchronous reset clears the store to black,
// both size registers to 1 and all control state; the receiver cannot stall result beats.
`timescale 1ns / 1ps
`default_nettype none

module led_color_buffer #(
   parameter int MAX_LEDS = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Command channel: a beat is taken when start is high and busy is low.
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [2:0]                        req_command,
   input  wire logic [5:0]                        req_fan,
   input  wire logic [5:0]                        req_led,
   input  wire logic [7:0]                        req_channel_value,
   input  wire logic [31:0]                       req_rgba,
   // Result channel: one beat per command, valid for the single cycle of rsp_strobe.
   output logic                                   rsp_strobe,
   output logic [7:0]                             rsp_red,
   output logic [7:0]                             rsp_green,
   output logic [7:0]                             rsp_blue,
   output logic [1:0]                             rsp_status,
   // Size registers; the user must write them only while idle, the block does not enforce it.
   input  wire logic                              csr_write_enable,
   input  wire logic [lcb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [lcb_pkg::CSR_DATA_W-1:0]    csr_data
);
   import lcb_pkg::*;

   // The two size registers. They feed the front end only: the front end turns
   // them into a start address, a stride and a beat count for each command, so the
   // back end never needs to look at the configuration.
   logic [CSR_DATA_W-1:0] fans_in_use_ff, fans_in_use_in;
   logic [CSR_DATA_W-1:0] leds_per_fan_ff, leds_per_fan_in;

   always_comb begin
      fans_in_use_in  = fans_in_use_ff;
      leds_per_fan_in = leds_per_fan_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FANS_IN_USE:  fans_in_use_in  = csr_data;
            CSR_LEDS_PER_FAN: leds_per_fan_in = csr_data;
            default:          fans_in_use_in  = fans_in_use_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fans_in_use_ff  <= CSR_DATA_W'(1);
         leds_per_fan_ff <= CSR_DATA_W'(1);
      end else begin
         fans_in_use_ff  <= fans_in_use_in;
         leds_per_fan_ff <= leds_per_fan_in;
      end
   end

   // The front end checks the configuration and the indices in the order
   // configuration, fan, LED, works out the store address and forms the three
   // color-times-alpha products, then holds the classified command in a register.
   logic      push;
   logic      q_full;
   entry_type push_entry;

   lcb_front #(
      .MAX_LEDS (MAX_LEDS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_command       (req_command),
      .req_fan           (req_fan),
      .req_led           (req_led),
      .req_channel_value (req_channel_value),
      .req_rgba          (req_rgba),
      .fans_in_use       (fans_in_use_ff),
      .leds_per_fan      (leds_per_fan_ff),
      .q_full            (q_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   // A two-beat queue lets new commands come in while a long fill is walking.
   logic      q_pop;
   logic      q_not_empty;
   entry_type q_head;

   lcb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   // The back end owns the color store. It finishes the divide by 255, walks
   // fills one entry per cycle, does read-modify-write for channel sets, and
   // registers exactly one result beat per command.
   lcb_back #(
      .MAX_LEDS (MAX_LEDS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_not_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue),
      .rsp_status (rsp_status)
   );

endmodule

`default_nettype wire
